// ===== src/i2cfb_pkg.sv =====
package i2cfb_pkg;

  // Event codes carried on the mode field of an input word.
  localparam logic [2:0] EV_WRITE_MATCH = 3'd0;
  localparam logic [2:0] EV_DATA        = 3'd1;
  localparam logic [2:0] EV_STOP        = 3'd2;
  localparam logic [2:0] EV_READ_MATCH  = 3'd3;
  localparam logic [2:0] EV_ACKED       = 3'd4;
  localparam logic [2:0] EV_READ_DONE   = 3'd5;
  localparam logic [2:0] EV_HOST_LOAD   = 3'd6;
  localparam logic [2:0] EV_HOST_POP    = 3'd7;

  // Fixed field widths and the size of the host send buffer.
  localparam int MODE_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int HOST_IDX_W = 5;
  localparam int SEND_DEPTH = 32;
  localparam int SEND_IDX_W = 6;
  localparam int FLEN_W     = 6;

endpackage

// ===== src/i2cfb_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
module i2cfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/i2c_slave_frame_buffer.sv =====
// I2C slave frame buffer. Each input word is one decoded bus event or host
// operation (write match, data received, stop, read match, byte acknowledged,
// read done, host load, host pop). Received frames, address byte first, are
// kept in a two-slot ring held in one RAM of 2 x FRAME_BYTES bytes; the bytes
// the master reads come from a 32-byte send buffer RAM that the host loads and
// that reads as zero until written. Events that produce no output word (write
// match, data, stop, read done, host load, and events in the wrong phase) are
// taken in the idle state, which stays ready for the next event. A read match
// or an acknowledge reads the send buffer and then, once the output register
// is free, loads it from the send state. A host pop walks the pending frame
// byte by byte: each byte is read from the receive RAM in the pop read state
// and loaded into the output register in the pop wait state. A pop with no
// pending frame gives one word with frame_valid low. The output register lets
// a new event be taken while the last output word still waits for out_ready_i.
module i2c_slave_frame_buffer
  import i2cfb_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic [HOST_IDX_W-1:0] host_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_W-1:0]     send_byte_o,
  output logic                  send_valid_o,
  output logic [BYTE_W-1:0]     frame_byte_o,
  output logic [FLEN_W-1:0]     frame_length_o,
  output logic                  frame_valid_o,
  output logic                  last_of_frame_o
);

  // Length and index width holds FRAME_BYTES itself; the receive RAM holds
  // both ring slots back to back.
  localparam int LEN_W   = $clog2(FRAME_BYTES + 1);
  localparam int RX_DEPTH = 2 * FRAME_BYTES;
  localparam int RX_AW   = $clog2(RX_DEPTH);
  localparam int SND_AW  = $clog2(SEND_DEPTH);

  // Bus phase.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_SEND = 2'd2;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEND     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_POP_RD   = 3'd3;
  localparam logic [2:0] ST_POP_WAIT = 3'd4;

  logic [2:0]            st_q, st_d;
  logic [1:0]            phase_q, phase_d;
  logic                  fill_slot_q, fill_slot_d;
  logic                  read_slot_q, read_slot_d;
  logic [LEN_W-1:0]      rx_idx_q, rx_idx_d;
  logic [SEND_IDX_W-1:0] snd_idx_q, snd_idx_d;
  logic [SEND_DEPTH-1:0] snd_vld_q, snd_vld_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [LEN_W-1:0]      slot_len_q [2];
  logic                  len_we;
  logic [LEN_W-1:0]      pop_idx_q, pop_idx_d;
  logic [LEN_W-1:0]      pop_len_q, pop_len_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;

  // Receive RAM ports.
  logic                  rx_we;
  logic [RX_AW-1:0]      rx_waddr;
  logic                  rx_re;
  logic [RX_AW-1:0]      rx_raddr;
  logic [BYTE_W-1:0]     rx_rdata;

  // Send RAM ports.
  logic                  snd_we;
  logic                  snd_re;
  logic [SND_AW-1:0]     snd_raddr;
  logic [BYTE_W-1:0]     snd_rdata;

  // Output register.
  logic                  out_valid_q;
  logic [BYTE_W-1:0]     send_byte_q, send_byte_d;
  logic                  send_valid_q, send_valid_d;
  logic [BYTE_W-1:0]     frame_byte_q, frame_byte_d;
  logic [FLEN_W-1:0]     frame_length_q, frame_length_d;
  logic                  frame_valid_q, frame_valid_d;
  logic                  last_q, last_d;

  // Byte address of position idx within a ring slot.
  function automatic logic [RX_AW-1:0] rx_addr(input logic slot, input logic [LEN_W-1:0] idx);
    logic [RX_AW-1:0] base;
    base = slot ? RX_AW'(FRAME_BYTES) : '0;
    return base + RX_AW'(idx);
  endfunction

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  i2cfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (data_byte_i),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  i2cfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SEND_DEPTH)
  ) u_snd_ram (
    .clk_i   (clk_i),
    .we_i    (snd_we),
    .waddr_i (host_index_i),
    .wdata_i (data_byte_i),
    .re_i    (snd_re),
    .raddr_i (snd_raddr),
    .rdata_o (snd_rdata)
  );

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    fill_slot_d = fill_slot_q;
    read_slot_d = read_slot_q;
    rx_idx_d    = rx_idx_q;
    snd_idx_d   = snd_idx_q;
    snd_vld_d   = snd_vld_q;
    rd_vld_d    = rd_vld_q;
    pop_idx_d   = pop_idx_q;
    pop_len_d   = pop_len_q;
    len_we      = 1'b0;
    rx_we       = 1'b0;
    rx_waddr    = rx_addr(fill_slot_q, rx_idx_q);
    rx_re       = 1'b0;
    rx_raddr    = rx_addr(read_slot_q, pop_idx_q);
    snd_we      = 1'b0;
    snd_re      = 1'b0;
    snd_raddr   = snd_idx_q[SND_AW-1:0];
    out_load    = 1'b0;

    send_byte_d    = '0;
    send_valid_d   = 1'b0;
    frame_byte_d   = '0;
    frame_length_d = '0;
    frame_valid_d  = 1'b0;
    last_d         = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_i)
            EV_WRITE_MATCH: begin
              if (phase_q == PH_IDLE) begin
                rx_we    = 1'b1;
                rx_waddr = rx_addr(fill_slot_q, '0);
                rx_idx_d = LEN_W'(1);
                phase_d  = PH_RECV;
              end
            end
            EV_DATA: begin
              // Bytes past the slot capacity are dropped.
              if (phase_q == PH_RECV && rx_idx_q < LEN_W'(FRAME_BYTES)) begin
                rx_we    = 1'b1;
                rx_idx_d = rx_idx_q + LEN_W'(1);
              end
            end
            EV_STOP: begin
              if (phase_q == PH_RECV) begin
                len_we   = 1'b1;
                rx_idx_d = LEN_W'(1);
                phase_d  = PH_IDLE;
                // With a frame already pending the ring is full, and the
                // next frame overwrites the filling slot.
                if (!fill_slot_q != read_slot_q) begin
                  fill_slot_d = !fill_slot_q;
                end
              end
            end
            EV_READ_MATCH: begin
              if (phase_q == PH_IDLE) begin
                phase_d   = PH_SEND;
                snd_idx_d = SEND_IDX_W'(1);
                snd_re    = 1'b1;
                snd_raddr = '0;
                rd_vld_d  = snd_vld_q[0];
                st_d      = ST_SEND;
              end
            end
            EV_ACKED: begin
              if (phase_q == PH_SEND) begin
                snd_re    = 1'b1;
                rd_vld_d  = snd_vld_q[snd_idx_q[SND_AW-1:0]];
                snd_idx_d = snd_idx_q + SEND_IDX_W'(1);
                st_d      = ST_SEND;
              end
            end
            EV_READ_DONE: begin
              if (phase_q == PH_SEND) begin
                phase_d   = PH_IDLE;
                snd_idx_d = SEND_IDX_W'(1);
              end
            end
            EV_HOST_LOAD: begin
              snd_we                  = 1'b1;
              snd_vld_d[host_index_i] = 1'b1;
            end
            EV_HOST_POP: begin
              if (fill_slot_q == read_slot_q) begin
                st_d = ST_EMPTY;
              end else begin
                pop_len_d = slot_len_q[read_slot_q];
                pop_idx_d = '0;
                st_d      = ST_POP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEND: begin
        if (out_free) begin
          out_load     = 1'b1;
          send_byte_d  = rd_vld_q ? snd_rdata : '0;
          send_valid_d = 1'b1;
          st_d         = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          last_d   = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        rx_re = 1'b1;
        st_d  = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          frame_byte_d   = rx_rdata;
          frame_length_d = FLEN_W'(pop_len_q);
          frame_valid_d  = 1'b1;
          if (pop_idx_q + LEN_W'(1) == pop_len_q) begin
            last_d      = 1'b1;
            read_slot_d = !read_slot_q;
            st_d        = ST_IDLE;
          end else begin
            pop_idx_d = pop_idx_q + LEN_W'(1);
            st_d      = ST_POP_RD;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      fill_slot_q <= 1'b0;
      read_slot_q <= 1'b0;
      rx_idx_q    <= LEN_W'(1);
      snd_idx_q   <= SEND_IDX_W'(1);
      snd_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      pop_idx_q   <= '0;
      pop_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      fill_slot_q <= fill_slot_d;
      read_slot_q <= read_slot_d;
      rx_idx_q    <= rx_idx_d;
      snd_idx_q   <= snd_idx_d;
      snd_vld_q   <= snd_vld_d;
      rd_vld_q    <= rd_vld_d;
      pop_idx_q   <= pop_idx_d;
      pop_len_q   <= pop_len_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot lengths and the output payload need no reset.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      slot_len_q[fill_slot_q] <= rx_idx_q;
    end
    if (out_load) begin
      send_byte_q    <= send_byte_d;
      send_valid_q   <= send_valid_d;
      frame_byte_q   <= frame_byte_d;
      frame_length_q <= frame_length_d;
      frame_valid_q  <= frame_valid_d;
      last_q         <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_byte_o     = send_byte_q;
  assign send_valid_o    = send_valid_q;
  assign frame_byte_o    = frame_byte_q;
  assign frame_length_o  = frame_length_q;
  assign frame_valid_o   = frame_valid_q;
  assign last_of_frame_o = last_q;

  // The receive index stays between one and FRAME_BYTES, never at position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_idx_q != '0 && rx_idx_q <= LEN_W'(FRAME_BYTES))
    else $error("receive index out of range");

  // A pop walk stays inside the committed frame length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POP_RD || st_q == ST_POP_WAIT) |-> pop_idx_q < pop_len_q)
    else $error("pop index past frame length");

  // A send word never carries frame fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> !frame_valid_o && !last_of_frame_o)
    else $error("send word carries frame fields");

  // A finished pop advances the read slot by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_POP_WAIT && out_load && last_d |=> read_slot_q != $past(read_slot_q))
    else $error("read slot did not advance after pop");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cfb_pkg::*;

  localparam int          FRAME_BYTES   = 32;
  localparam int          CLK_PERIOD    = 20;
  localparam int          RESET_CYCLES  = 5;
  localparam int unsigned RANDOM_EVENTS = 300;
  // The drain after the last reply only has to outlast one full 32-byte pop
  // by a comfortable margin.
  localparam int          DRAIN_CYCLES  = 150;
  // Longest run of cycles without a single accepted word before the run is
  // declared hung.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned REPORT_MAX    = 10;

  // One input word: a decoded bus event or a host operation.
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [BYTE_W-1:0]     data_byte;
    logic [HOST_IDX_W-1:0] host_index;
  } bus_event_t;

  // One output word, either a byte for the master or a byte of a popped frame.
  typedef struct packed {
    logic [BYTE_W-1:0] send_byte;
    logic              send_valid;
    logic [BYTE_W-1:0] frame_byte;
    logic [FLEN_W-1:0] frame_length;
    logic              frame_valid;
    logic              last_of_frame;
  } reply_t;

  typedef enum logic [1:0] {LINK_IDLE, LINK_RECV, LINK_SEND} link_phase_e;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [MODE_W-1:0]     mode_i       = '0;
  logic [BYTE_W-1:0]     data_byte_i  = '0;
  logic [HOST_IDX_W-1:0] host_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [BYTE_W-1:0]     send_byte_o;
  logic                  send_valid_o;
  logic [BYTE_W-1:0]     frame_byte_o;
  logic [FLEN_W-1:0]     frame_length_o;
  logic                  frame_valid_o;
  logic                  last_of_frame_o;

  i2c_slave_frame_buffer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .host_index_i   (host_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .send_byte_o    (send_byte_o),
    .send_valid_o   (send_valid_o),
    .frame_byte_o   (frame_byte_o),
    .frame_length_o (frame_length_o),
    .frame_valid_o  (frame_valid_o),
    .last_of_frame_o(last_of_frame_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Words still to be driven, and the replies the block owes us, oldest first.
  bus_event_t  event_backlog[$];
  reply_t      due_replies[$];
  bus_event_t  drive_word;

  int unsigned total_events    = 0;
  int unsigned accepted_events = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned mismatches      = 0;

  // Shadow copy of the slave: link phase, the two-slot frame ring, the host
  // send buffer and the bus-side send pointer.
  link_phase_e           link_phase  = LINK_IDLE;
  logic [BYTE_W-1:0]     frame_ram[2*FRAME_BYTES];
  logic [FLEN_W-1:0]     slot_len[2];
  logic                  fill_slot_q = 1'b0;
  logic                  read_slot_q = 1'b0;
  int unsigned           rx_count    = 1;
  logic [BYTE_W-1:0]     tx_ram[SEND_DEPTH];
  logic [SEND_IDX_W-1:0] tx_index    = SEND_IDX_W'(1);

  // Advance the shadow slave by one accepted word and queue the replies it
  // must produce. Events arriving in the wrong phase fall through untouched.
  task automatic predict_event(input bus_event_t ev);
    reply_t      r;
    int unsigned len;
    int unsigned base;
    r = '0;
    case (ev.mode)
      EV_WRITE_MATCH: begin
        // The matched address byte becomes byte 0 of the filling slot.
        if (link_phase == LINK_IDLE) begin
          frame_ram[int'(fill_slot_q) * FRAME_BYTES] = ev.data_byte;
          rx_count   = 1;
          link_phase = LINK_RECV;
        end
      end
      EV_DATA: begin
        // Bytes past the frame capacity are silently dropped.
        if (link_phase == LINK_RECV && rx_count < FRAME_BYTES) begin
          frame_ram[int'(fill_slot_q) * FRAME_BYTES + rx_count] = ev.data_byte;
          rx_count++;
        end
      end
      EV_STOP: begin
        // Commit the length. The ring only advances when the next slot is
        // not the one still waiting to be popped; otherwise the next frame
        // overwrites the slot that was just filled.
        if (link_phase == LINK_RECV) begin
          slot_len[fill_slot_q] = FLEN_W'(rx_count);
          rx_count   = 1;
          link_phase = LINK_IDLE;
          if ((fill_slot_q ^ 1'b1) != read_slot_q) begin
            fill_slot_q = ~fill_slot_q;
          end
        end
      end
      EV_READ_MATCH: begin
        if (link_phase == LINK_IDLE) begin
          link_phase   = LINK_SEND;
          tx_index     = SEND_IDX_W'(1);
          r.send_byte  = tx_ram[0];
          r.send_valid = 1'b1;
          due_replies.push_back(r);
        end
      end
      EV_ACKED: begin
        // The send pointer is six bits wide but the buffer only 32 deep, so
        // the buffer is addressed by the low bits and the pointer wraps.
        if (link_phase == LINK_SEND) begin
          r.send_byte  = tx_ram[tx_index[HOST_IDX_W-1:0]];
          r.send_valid = 1'b1;
          due_replies.push_back(r);
          tx_index = tx_index + 1'b1;
        end
      end
      EV_READ_DONE: begin
        if (link_phase == LINK_SEND) begin
          link_phase = LINK_IDLE;
          tx_index   = SEND_IDX_W'(1);
        end
      end
      EV_HOST_LOAD: begin
        tx_ram[ev.host_index] = ev.data_byte;
      end
      default: begin
        // Host pop. An empty ring answers with one word carrying only the
        // last flag; a pending frame comes out one word per byte.
        if (fill_slot_q == read_slot_q) begin
          r.last_of_frame = 1'b1;
          due_replies.push_back(r);
        end else begin
          len = slot_len[read_slot_q];
          if (len < 1) len = 1;
          if (len > FRAME_BYTES) len = FRAME_BYTES;
          base = int'(read_slot_q) * FRAME_BYTES;
          for (int i = 0; i < len; i++) begin
            r               = '0;
            r.frame_byte    = frame_ram[base + i];
            r.frame_length  = FLEN_W'(len);
            r.frame_valid   = 1'b1;
            r.last_of_frame = (i + 1 == len);
            due_replies.push_back(r);
          end
          read_slot_q = ~read_slot_q;
        end
      end
    endcase
  endtask

  // The run is split into four equal stretches by accepted input words:
  // no idling, sender idle, receiver stalling, then both at once.
  function automatic int unsigned idle_pct(input bit receiver_side);
    int unsigned quarter;
    quarter = (total_events == 0) ? 0 : (accepted_events * 4) / total_events;
    case (quarter)
      0:       return 0;
      1:       return receiver_side ? 0 : 56;
      2:       return receiver_side ? 56 : 0;
      default: return 31;
    endcase
  endfunction

  task automatic push_event(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                            input logic [HOST_IDX_W-1:0] index);
    bus_event_t ev;
    ev.mode       = mode;
    ev.data_byte  = data;
    ev.host_index = index;
    event_backlog.push_back(ev);
  endtask

  // Every field is randomized, even the ones the event ignores, so that all
  // input bits toggle throughout the run.
  task automatic push_random(input logic [MODE_W-1:0] mode);
    push_event(mode, BYTE_W'($urandom_range(255)), HOST_IDX_W'($urandom_range(31)));
  endtask

  task automatic report_reply(input string why, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s", $time, why);
      $display("  expected sb=%02h sv=%0d fb=%02h len=%0d fv=%0d last=%0d",
               want.send_byte, want.send_valid, want.frame_byte,
               want.frame_length, want.frame_valid, want.last_of_frame);
      $display("  actual   sb=%02h sv=%0d fb=%02h len=%0d fv=%0d last=%0d",
               got.send_byte, got.send_valid, got.frame_byte,
               got.frame_length, got.frame_valid, got.last_of_frame);
    end
  endtask

  // Input driver. A word is handed to the prediction at the edge where it is
  // accepted; the next one is then presented, or valid drops while the driver
  // idles. Valid is only ever written once per edge, so a word that follows
  // directly keeps valid high without a glitch.
  always @(posedge clk_i) begin : input_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_event(drive_word);
        accepted_events <= accepted_events + 1;
      end
      if (event_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        drive_word    = event_backlog.pop_front();
        mode_i       <= drive_word.mode;
        data_byte_i  <= drive_word.data_byte;
        host_index_i <= drive_word.host_index;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor. Each accepted word is checked against the oldest reply
  // still owed; ready is redrawn every cycle to stall the block at random.
  always @(posedge clk_i) begin : reply_monitor
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.send_byte     = send_byte_o;
        got.send_valid    = send_valid_o;
        got.frame_byte    = frame_byte_o;
        got.frame_length  = frame_length_o;
        got.frame_valid   = frame_valid_o;
        got.last_of_frame = last_of_frame_o;
        if (due_replies.size() == 0) begin
          report_reply("output word with no reply due", '0, got);
        end else begin
          want = due_replies.pop_front();
          if (got.send_byte !== want.send_byte || got.send_valid !== want.send_valid ||
              got.frame_byte !== want.frame_byte ||
              got.frame_length !== want.frame_length ||
              got.frame_valid !== want.frame_valid ||
              got.last_of_frame !== want.last_of_frame) begin
            report_reply("output word mismatch", want, got);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Watchdog: cycles since the last word moved on either channel.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned count;
    int unsigned directed_events;
    bit          timed_out;

    foreach (tx_ram[i]) tx_ram[i] = '0;

    // Directed part. A pop on the empty ring, host loads at both ends of
    // the send buffer with all-ones and all-zeros bytes, and bus events that
    // arrive while idle and must be ignored.
    push_event(EV_HOST_POP,    8'h00, 5'd0);
    push_event(EV_HOST_LOAD,   8'hFF, 5'd0);
    push_event(EV_HOST_LOAD,   8'h00, 5'd31);
    push_event(EV_HOST_LOAD,   8'hA5, 5'd1);
    push_event(EV_ACKED,       8'h11, 5'd2);
    push_event(EV_READ_DONE,   8'h22, 5'd3);
    push_event(EV_DATA,        8'h33, 5'd4);
    push_event(EV_STOP,        8'h44, 5'd5);
    // A three-byte frame with a stray write match and read match in the
    // middle, both of which the receiving phase must ignore.
    push_event(EV_WRITE_MATCH, 8'hA0, 5'd31);
    push_event(EV_DATA,        8'hFF, 5'd0);
    push_event(EV_WRITE_MATCH, 8'h70, 5'd6);
    push_event(EV_READ_MATCH,  8'hB8, 5'd7);
    push_event(EV_DATA,        8'h00, 5'd8);
    push_event(EV_STOP,        8'hA8, 5'd9);
    // With one frame pending the ring is full: an address-only frame and
    // then a longer one both land in the same slot, the second overwriting.
    push_event(EV_WRITE_MATCH, 8'h60, 5'd10);
    push_event(EV_STOP,        8'h00, 5'd11);
    push_event(EV_WRITE_MATCH, 8'hC8, 5'd12);
    push_event(EV_DATA,        8'h5A, 5'd13);
    push_event(EV_STOP,        8'h00, 5'd14);
    // The first pop returns the kept frame, the second finds the ring empty.
    push_event(EV_HOST_POP,    8'h00, 5'd15);
    push_event(EV_HOST_POP,    8'h00, 5'd16);
    // A master read of the loaded bytes, with a data byte that the sending
    // phase must ignore.
    push_event(EV_READ_MATCH,  8'h00, 5'd17);
    push_event(EV_ACKED,       8'h00, 5'd18);
    push_event(EV_DATA,        8'h77, 5'd19);
    push_event(EV_ACKED,       8'h00, 5'd20);
    push_event(EV_READ_DONE,   8'h00, 5'd21);
    directed_events = event_backlog.size();

    // Random part. Mostly whole bus transactions with random content, so the
    // receive and send phases are actually exercised. A few frames run past
    // capacity, a few reads walk past the end of the send buffer and wrap the
    // send pointer, and some transactions lose their closing event. The rest
    // is host traffic and single events of any kind.
    while (event_backlog.size() < directed_events + RANDOM_EVENTS) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        count = ($urandom_range(11) == 0) ? $urandom_range(FRAME_BYTES + 4, FRAME_BYTES - 4)
                                          : $urandom_range(6);
        push_random(EV_WRITE_MATCH);
        repeat (count) push_random(EV_DATA);
        if ($urandom_range(9) != 0) push_random(EV_STOP);
      end else if (pick < 50) begin
        count = ($urandom_range(14) == 0) ? $urandom_range(70, 30) : $urandom_range(5);
        push_random(EV_READ_MATCH);
        repeat (count) push_random(EV_ACKED);
        if ($urandom_range(9) != 0) push_random(EV_READ_DONE);
      end else if (pick < 65) begin
        repeat ($urandom_range(3, 1)) push_random(EV_HOST_LOAD);
      end else if (pick < 85) begin
        push_random(EV_HOST_POP);
      end else begin
        push_random(MODE_W'($urandom_range(EV_HOST_POP, EV_WRITE_MATCH)));
      end
    end
    total_events = event_backlog.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until every word has gone in and every owed reply has come out,
    // unless the watchdog trips first.
    timed_out = 1'b0;
    while (!timed_out &&
           (event_backlog.size() != 0 || in_valid_i || due_replies.size() != 0)) begin
      @(posedge clk_i);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end

    // Drain: any stray word the block still emits is caught by the monitor.
    for (count = 0; count < DRAIN_CYCLES && !timed_out; count++) begin
      @(posedge clk_i);
    end

    if (!timed_out && mismatches == 0 && due_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
